### rtl/core/cmb_pkg.sv
// Package for the color mix blend unit: pixel and factor types, register
// indexes, mode codes and the configuration struct. Depends on nothing.
`default_nettype none

package cmb_pkg;

  localparam int Q_W = 16;
  typedef logic signed [Q_W-1:0] q_t;

  // 1.0 in Q3.12 and the saturation limits of a channel.
  localparam q_t Q_ONE = 16'sd4096;
  localparam int Q_MAX = 32767;
  localparam int Q_MIN = -32768;

  typedef struct packed {
    q_t r;
    q_t g;
    q_t b;
  } rgb_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAC_PER_CHAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_FAC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_OUT    = 3'd4;

  // Data type codes; the fourth code is unused and yields zero.
  localparam logic [1:0] DT_COLOR  = 2'd0;
  localparam logic [1:0] DT_FLOAT  = 2'd1;
  localparam logic [1:0] DT_VECTOR = 2'd2;

  // Color mode blend codes; the fourth code is unused and yields zero.
  localparam logic [1:0] BM_MIX = 2'd0;
  localparam logic [1:0] BM_MUL = 2'd1;
  localparam logic [1:0] BM_ADD = 2'd2;

  typedef struct packed {
    logic [1:0] operand_kind;
    logic       fac_per_chan;
    logic [1:0] blend_mode;
    logic       clamp_fac;
    logic       clamp_out;
  } cfg_t;

  // Operation a channel takes through the lerp pipeline.
  typedef enum logic [1:0] {
    OP_MIX,
    OP_ADD,
    OP_MUL,
    OP_ZERO
  } op_t;

endpackage

`default_nettype wire

### rtl/core/cmb_in_if.sv
// Request channel carrying the A, B and factor colors of one pixel.
// Depends on cmb_pkg for the channel type.
`default_nettype none

interface cmb_in_if;
  logic      valid;
  logic      ready;
  cmb_pkg::q_t a_r;
  cmb_pkg::q_t a_g;
  cmb_pkg::q_t a_b;
  cmb_pkg::q_t b_r;
  cmb_pkg::q_t b_g;
  cmb_pkg::q_t b_b;
  cmb_pkg::q_t fac_r;
  cmb_pkg::q_t fac_g;
  cmb_pkg::q_t fac_b;

  modport source (output valid, a_r, a_g, a_b, b_r, b_g, b_b, fac_r, fac_g, fac_b,
                  input ready);
  modport sink (input valid, a_r, a_g, a_b, b_r, b_g, b_b, fac_r, fac_g, fac_b,
                output ready);
endinterface

`default_nettype wire

### rtl/core/cmb_out_if.sv
// Result channel carrying one blended color.
// Depends on cmb_pkg for the channel type.
`default_nettype none

interface cmb_out_if;
  logic        valid;
  logic        ready;
  cmb_pkg::q_t out_r;
  cmb_pkg::q_t out_g;
  cmb_pkg::q_t out_b;

  modport source (output valid, out_r, out_g, out_b, input ready);
  modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

`default_nettype wire

### rtl/core/cmb_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on cmb_pkg for the field widths.
`default_nettype none

interface cmb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cmb_pkg::CFG_IDX_W-1:0]    index;
  logic [cmb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/cmb_mean_stage.sv
// First two pipeline stages: biased channel sums, then mean of three by
// reciprocal multiplication. Depends on cmb_pkg.
`default_nettype none

module cmb_mean_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire cmb_pkg::rgb_t a_in,
  input  wire cmb_pkg::rgb_t b_in,
  input  wire cmb_pkg::rgb_t f_in,
  output      logic          valid_o,
  output      cmb_pkg::rgb_t a_o,
  output      cmb_pkg::rgb_t b_o,
  output      cmb_pkg::rgb_t f_o,
  output      cmb_pkg::q_t   ma_o,
  output      cmb_pkg::q_t   mb_o,
  output      cmb_pkg::q_t   mf_o
);

  localparam int SUM_W = 18;
  // Sum plus one for rounding plus 3*32768 keeps the value non-negative.
  localparam logic signed [SUM_W:0] SUM_BIAS = 19'sd98305;
  // ceil(2^19 / 3): exact floor division by three for any 18-bit value.
  localparam int RECIP_SHIFT = 19;
  localparam logic [SUM_W-1:0] RECIP = 18'd174763;

  function automatic logic [SUM_W-1:0] biased_sum(input cmb_pkg::q_t x,
                                                  input cmb_pkg::q_t y,
                                                  input cmb_pkg::q_t z);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(x) + (SUM_W+1)'(y) + (SUM_W+1)'(z) + SUM_BIAS;
    return s[SUM_W-1:0];
  endfunction

  // The quotient lies in 0..65535; removing the bias flips its top bit.
  function automatic cmb_pkg::q_t mean_of(input logic [SUM_W-1:0] u);
    logic [2*SUM_W-1:0] p;
    p = (2*SUM_W)'(u) * (2*SUM_W)'(RECIP);
    return {~p[RECIP_SHIFT+15], p[RECIP_SHIFT+14:RECIP_SHIFT]};
  endfunction

  logic            v1_r;
  cmb_pkg::rgb_t   a1_r, b1_r, f1_r;
  logic [SUM_W-1:0] ua1_r, ub1_r, uf1_r;
  logic [SUM_W-1:0] ua1_nxt, ub1_nxt, uf1_nxt;

  logic            v2_r;
  cmb_pkg::rgb_t   a2_r, b2_r, f2_r;
  cmb_pkg::q_t     ma2_r, mb2_r, mf2_r;
  cmb_pkg::q_t     ma2_nxt, mb2_nxt, mf2_nxt;

  assign ua1_nxt = biased_sum(a_in.r, a_in.g, a_in.b);
  assign ub1_nxt = biased_sum(b_in.r, b_in.g, b_in.b);
  assign uf1_nxt = biased_sum(f_in.r, f_in.g, f_in.b);

  assign ma2_nxt = mean_of(ua1_r);
  assign mb2_nxt = mean_of(ub1_r);
  assign mf2_nxt = mean_of(uf1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= a_in;
      b1_r  <= b_in;
      f1_r  <= f_in;
      ua1_r <= ua1_nxt;
      ub1_r <= ub1_nxt;
      uf1_r <= uf1_nxt;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      f2_r  <= f1_r;
      ma2_r <= ma2_nxt;
      mb2_r <= mb2_nxt;
      mf2_r <= mf2_nxt;
    end
  end

  assign valid_o = v2_r;
  assign a_o     = a2_r;
  assign b_o     = b2_r;
  assign f_o     = f2_r;
  assign ma_o    = ma2_r;
  assign mb_o    = mb2_r;
  assign mf_o    = mf2_r;

endmodule

`default_nettype wire

### rtl/core/cmb_blend_stage.sv
// Last three pipeline stages: operand selection and first product, second
// product for multiply, then rounding, saturation and clamps. Depends on cmb_pkg.
`default_nettype none

module cmb_blend_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire cmb_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire cmb_pkg::rgb_t a_in,
  input  wire cmb_pkg::rgb_t b_in,
  input  wire cmb_pkg::rgb_t f_in,
  input  wire cmb_pkg::q_t   ma,
  input  wire cmb_pkg::q_t   mb,
  input  wire cmb_pkg::q_t   mf,
  output      logic          valid_o,
  output      cmb_pkg::rgb_t res_o
);

  localparam int NCH   = 3;
  localparam int X_W   = cmb_pkg::Q_W + 1;
  localparam int M1_W  = X_W + cmb_pkg::Q_W;
  localparam int M2_W  = M1_W + X_W;
  localparam int ACC_W = M2_W + 1;
  localparam int SH_LO = 12;
  localparam int SH_HI = 24;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(cmb_pkg::Q_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(cmb_pkg::Q_MIN);
  localparam logic signed [ACC_W-1:0] HALF_LO = ACC_W'(1) <<< (SH_LO - 1);
  localparam logic signed [ACC_W-1:0] HALF_HI = ACC_W'(1) <<< (SH_HI - 1);

  function automatic cmb_pkg::q_t clamp01(input cmb_pkg::q_t v);
    cmb_pkg::q_t r;
    r = v;
    if (v < 0) r = '0;
    else if (v > cmb_pkg::Q_ONE) r = cmb_pkg::Q_ONE;
    return r;
  endfunction

  cmb_pkg::q_t a_ch [NCH];
  cmb_pkg::q_t b_ch [NCH];
  cmb_pkg::q_t f_ch [NCH];
  cmb_pkg::q_t fm;
  logic        clamp_res_en;

  logic                     v3_r, v4_r, v5_r;
  logic signed [M1_W-1:0]   m1_r   [NCH];
  logic signed [M1_W-1:0]   m1_nxt [NCH];
  cmb_pkg::q_t              a3_r   [NCH];
  cmb_pkg::q_t              a3_nxt [NCH];
  logic signed [X_W-1:0]    bm3_r  [NCH];
  logic signed [X_W-1:0]    bm3_nxt[NCH];
  cmb_pkg::op_t             op3_r  [NCH];
  cmb_pkg::op_t             op3_nxt[NCH];
  logic signed [ACC_W-1:0]  prod4_r   [NCH];
  logic signed [ACC_W-1:0]  prod4_nxt [NCH];
  logic signed [ACC_W-1:0]  base4_r   [NCH];
  logic signed [ACC_W-1:0]  base4_nxt [NCH];
  cmb_pkg::op_t             op4_r  [NCH];
  cmb_pkg::q_t              res5_r   [NCH];
  cmb_pkg::q_t              res5_nxt [NCH];

  assign a_ch[0] = a_in.r;
  assign a_ch[1] = a_in.g;
  assign a_ch[2] = a_in.b;
  assign b_ch[0] = b_in.r;
  assign b_ch[1] = b_in.g;
  assign b_ch[2] = b_in.b;
  assign f_ch[0] = f_in.r;
  assign f_ch[1] = f_in.g;
  assign f_ch[2] = f_in.b;

  assign fm           = cfg.clamp_fac ? clamp01(mf) : mf;
  assign clamp_res_en = (cfg.operand_kind == cmb_pkg::DT_COLOR) && cfg.clamp_out;

  for (genvar g = 0; g < NCH; g++) begin : g_ch

    cmb_pkg::q_t           oa, ob, of;
    cmb_pkg::op_t          op;
    logic signed [X_W-1:0] x;
    logic signed [M2_W-1:0] mulp;
    logic signed [ACC_W-1:0] sum, sh;
    cmb_pkg::q_t           sat;

    // Stage 3: pick operands, form the first product.
    always_comb begin
      oa = a_ch[g];
      ob = b_ch[g];
      of = fm;
      op = cmb_pkg::OP_ZERO;
      case (cfg.operand_kind)
        cmb_pkg::DT_FLOAT: begin
          oa = ma;
          ob = mb;
          op = cmb_pkg::OP_MIX;
        end
        cmb_pkg::DT_VECTOR: begin
          op = cmb_pkg::OP_MIX;
          if (cfg.fac_per_chan) begin
            of = cfg.clamp_fac ? clamp01(f_ch[g]) : f_ch[g];
          end
        end
        cmb_pkg::DT_COLOR: begin
          case (cfg.blend_mode)
            cmb_pkg::BM_MIX: op = cmb_pkg::OP_MIX;
            cmb_pkg::BM_MUL: op = cmb_pkg::OP_MUL;
            cmb_pkg::BM_ADD: op = cmb_pkg::OP_ADD;
            default:         op = cmb_pkg::OP_ZERO;
          endcase
        end
        default: op = cmb_pkg::OP_ZERO;
      endcase

      // Mix is a*1 + (b-a)*f, add is a*1 + b*f, multiply starts with a*f.
      case (op)
        cmb_pkg::OP_MIX: x = X_W'(ob) - X_W'(oa);
        cmb_pkg::OP_ADD: x = X_W'(ob);
        default:         x = X_W'(oa);
      endcase

      m1_nxt[g]  = M1_W'(x) * M1_W'(of);
      a3_nxt[g]  = oa;
      bm3_nxt[g] = X_W'(ob) - X_W'(cmb_pkg::Q_ONE);
      op3_nxt[g] = op;
    end

    // Stage 4: multiply finishes as a*1*1 + (a*f)*(b-1) at the finer scale.
    assign mulp = m1_r[g] * bm3_r[g];

    always_comb begin
      if (op3_r[g] == cmb_pkg::OP_MUL) begin
        prod4_nxt[g] = ACC_W'(mulp);
        base4_nxt[g] = ACC_W'(a3_r[g]) <<< SH_HI;
      end else begin
        prod4_nxt[g] = ACC_W'(m1_r[g]);
        base4_nxt[g] = ACC_W'(a3_r[g]) <<< SH_LO;
      end
    end

    // Stage 5: round half up, saturate, then the optional result clamp.
    always_comb begin
      if (op4_r[g] == cmb_pkg::OP_MUL) begin
        sum = prod4_r[g] + base4_r[g] + HALF_HI;
        sh  = sum >>> SH_HI;
      end else begin
        sum = prod4_r[g] + base4_r[g] + HALF_LO;
        sh  = sum >>> SH_LO;
      end
      if (sh > SAT_HI) sat = cmb_pkg::q_t'(cmb_pkg::Q_MAX);
      else if (sh < SAT_LO) sat = cmb_pkg::q_t'(cmb_pkg::Q_MIN);
      else sat = sh[cmb_pkg::Q_W-1:0];
      if (op4_r[g] == cmb_pkg::OP_ZERO) res5_nxt[g] = '0;
      else if (clamp_res_en) res5_nxt[g] = clamp01(sat);
      else res5_nxt[g] = sat;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m1_r[g]    <= m1_nxt[g];
        a3_r[g]    <= a3_nxt[g];
        bm3_r[g]   <= bm3_nxt[g];
        op3_r[g]   <= op3_nxt[g];
        prod4_r[g] <= prod4_nxt[g];
        base4_r[g] <= base4_nxt[g];
        op4_r[g]   <= op3_r[g];
        res5_r[g]  <= res5_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign valid_o = v5_r;
  assign res_o.r = res5_r[0];
  assign res_o.g = res5_r[1];
  assign res_o.b = res5_r[2];

endmodule

`default_nettype wire

### rtl/core/color_mix_blend_unit.sv
// Top level of the color mix blend unit: configuration registers, pipeline
// flow control and checks. Depends on cmb_pkg, the channel interfaces,
// cmb_mean_stage and cmb_blend_stage.
`default_nettype none

// The unit blends two colors A and B under a factor color, one pixel per
// request. It accepts a new request in every clock cycle unless a finished
// result waits to be taken, and returns results in request order. The
// pipeline has five register stages: channel sums, mean of three
// by reciprocal multiplication, operand selection with the first product,
// the second product of the multiply blend, and rounding with saturation.
// All stages advance together; when a finished result is not taken, the
// whole pipeline holds, empty stages included, and no request is taken
// until the result moves. All numbers are signed Q3.12.
// The factor is the rounded mean of the three factor channels, or in vector
// mode with the per-channel factor each channel's own value, optionally
// clamped to 0..1. Float mode returns a gray lerp of the channel means of A
// and B; vector mode lerps each channel; color mode applies mix, multiply or
// add as a lerp from A, with an optional clamp of the result to 0..1. The
// unused data type and, in color mode, the unused blend code give zero.
// Rounding is to nearest with ties upward; results saturate to 16 bits.
// Configuration writes are always accepted and take effect at once; they
// should be made only while no request is in flight.

module color_mix_blend_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  cmb_in_if.sink    in_chan,
  cmb_out_if.source out_chan,
  cmb_cfg_if.sink   cfg_chan
);

  logic [1:0]    operand_kind_r;
  logic          fac_per_chan_r;
  logic [1:0]    blend_mode_r;
  logic          clamp_fac_r;
  logic          clamp_out_r;
  cmb_pkg::cfg_t cfg;

  logic          adv;
  logic          res_valid;
  cmb_pkg::rgb_t a_in, b_in, f_in;
  cmb_pkg::rgb_t a_m, b_m, f_m;
  cmb_pkg::q_t   ma, mb, mf;
  logic          m_valid;
  cmb_pkg::rgb_t res;

  // Registers take their low bits only; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operand_kind_r <= cmb_pkg::DT_COLOR;
      fac_per_chan_r <= 1'b0;
      blend_mode_r   <= cmb_pkg::BM_MIX;
      clamp_fac_r    <= 1'b0;
      clamp_out_r    <= 1'b0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        cmb_pkg::CFG_OPERAND_KIND: operand_kind_r <= cfg_chan.data[1:0];
        cmb_pkg::CFG_FAC_PER_CHAN: fac_per_chan_r <= cfg_chan.data[0];
        cmb_pkg::CFG_BLEND_MODE:   blend_mode_r   <= cfg_chan.data[1:0];
        cmb_pkg::CFG_CLAMP_FAC:    clamp_fac_r    <= cfg_chan.data[0];
        cmb_pkg::CFG_CLAMP_OUT:    clamp_out_r    <= cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  assign cfg.operand_kind = operand_kind_r;
  assign cfg.fac_per_chan = fac_per_chan_r;
  assign cfg.blend_mode   = blend_mode_r;
  assign cfg.clamp_fac    = clamp_fac_r;
  assign cfg.clamp_out    = clamp_out_r;

  // The pipeline moves whenever its last stage is empty or being drained.
  assign adv           = !res_valid || out_chan.ready;
  assign in_chan.ready = adv;

  assign a_in = '{r: in_chan.a_r, g: in_chan.a_g, b: in_chan.a_b};
  assign b_in = '{r: in_chan.b_r, g: in_chan.b_g, b: in_chan.b_b};
  assign f_in = '{r: in_chan.fac_r, g: in_chan.fac_g, b: in_chan.fac_b};

  cmb_mean_stage u_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_chan.valid),
    .a_in     (a_in),
    .b_in     (b_in),
    .f_in     (f_in),
    .valid_o  (m_valid),
    .a_o      (a_m),
    .b_o      (b_m),
    .f_o      (f_m),
    .ma_o     (ma),
    .mb_o     (mb),
    .mf_o     (mf)
  );

  cmb_blend_stage u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (m_valid),
    .a_in     (a_m),
    .b_in     (b_m),
    .f_in     (f_m),
    .ma       (ma),
    .mb       (mb),
    .mf       (mf),
    .valid_o  (res_valid),
    .res_o    (res)
  );

  assign out_chan.valid = res_valid;
  assign out_chan.out_r = res.r;
  assign out_chan.out_g = res.g;
  assign out_chan.out_b = res.b;

  // A result that waits must hold the whole pipeline, including the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !in_chan.ready)
    else $error("request taken while a result is stalled");

  // A request that is taken and then moves through the pipeline with no stall comes out as a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_chan.valid && in_chan.ready, 5) && $past(adv, 4) && $past(adv, 3) &&
    $past(adv, 2) && $past(adv, 1) && $past(rst_n, 4) && $past(rst_n, 3) &&
    $past(rst_n, 2) && $past(rst_n, 1) |-> out_chan.valid)
    else $error("request lost in the pipeline");

  // Float mode gives a gray result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && operand_kind_r == cmb_pkg::DT_FLOAT |->
    out_chan.out_r == out_chan.out_g && out_chan.out_g == out_chan.out_b)
    else $error("float mode result is not gray");

  // The result clamp in color mode keeps every channel within 0..1.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && operand_kind_r == cmb_pkg::DT_COLOR && clamp_out_r |->
    out_chan.out_r >= 0 && out_chan.out_r <= cmb_pkg::Q_ONE &&
    out_chan.out_g >= 0 && out_chan.out_g <= cmb_pkg::Q_ONE &&
    out_chan.out_b >= 0 && out_chan.out_b <= cmb_pkg::Q_ONE)
    else $error("clamped result out of range");

endmodule

`default_nettype wire

### dv/cmb_blend_sb_pkg.sv
// Scoreboard for the color mix blend unit testbench: a bit-exact predictor of
// the blend arithmetic and a class that queues and checks blended colors.
// Depends on cmb_pkg for the channel, configuration and mode types.

package cmb_blend_sb_pkg;

  function automatic cmb_pkg::q_t saturate(longint v);
    if (v > cmb_pkg::Q_MAX) return cmb_pkg::q_t'(cmb_pkg::Q_MAX);
    if (v < cmb_pkg::Q_MIN) return cmb_pkg::q_t'(cmb_pkg::Q_MIN);
    return cmb_pkg::q_t'(v);
  endfunction

  // Round to nearest with ties upward; the arithmetic shift floors.
  function automatic cmb_pkg::q_t round_shift(longint p, int shift);
    return saturate((p + (longint'(1) <<< (shift - 1))) >>> shift);
  endfunction

  function automatic cmb_pkg::q_t mean_of_three(cmb_pkg::q_t x, cmb_pkg::q_t y,
                                                cmb_pkg::q_t z);
    longint n;
    longint q;
    n = longint'(x) + longint'(y) + longint'(z) + 1;
    q = n / 3;
    if (n % 3 != 0 && n < 0) q = q - 1;
    return cmb_pkg::q_t'(q);
  endfunction

  function automatic cmb_pkg::q_t clamp_unit(cmb_pkg::q_t v, logic on);
    if (!on) return v;
    if (v < 0) return '0;
    if (v > cmb_pkg::Q_ONE) return cmb_pkg::Q_ONE;
    return v;
  endfunction

  function automatic cmb_pkg::q_t lerp_mix(cmb_pkg::q_t a, cmb_pkg::q_t b,
                                           cmb_pkg::q_t f);
    return round_shift(longint'(b) * longint'(f)
                       + longint'(a) * (longint'(cmb_pkg::Q_ONE) - longint'(f)), 12);
  endfunction

  function automatic cmb_pkg::q_t lerp_add(cmb_pkg::q_t a, cmb_pkg::q_t b,
                                           cmb_pkg::q_t f);
    return round_shift(longint'(a) * (longint'(cmb_pkg::Q_ONE) - longint'(f))
                       + (longint'(a) + longint'(b)) * longint'(f), 12);
  endfunction

  function automatic cmb_pkg::q_t lerp_mul(cmb_pkg::q_t a, cmb_pkg::q_t b,
                                           cmb_pkg::q_t f);
    return round_shift(longint'(a) * (longint'(cmb_pkg::Q_ONE) - longint'(f))
                       * longint'(cmb_pkg::Q_ONE)
                       + longint'(a) * longint'(b) * longint'(f), 24);
  endfunction

  class blend_scoreboard;
    cmb_pkg::cfg_t regs;
    cmb_pkg::rgb_t pending_colors[$];
    int unsigned   errors;

    function new();
      regs   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [cmb_pkg::CFG_IDX_W-1:0] index,
                            logic [cmb_pkg::CFG_DATA_W-1:0] data);
      case (index)
        cmb_pkg::CFG_OPERAND_KIND: regs.operand_kind = data[1:0];
        cmb_pkg::CFG_FAC_PER_CHAN: regs.fac_per_chan = data[0];
        cmb_pkg::CFG_BLEND_MODE:   regs.blend_mode   = data[1:0];
        cmb_pkg::CFG_CLAMP_FAC:    regs.clamp_fac    = data[0];
        cmb_pkg::CFG_CLAMP_OUT:    regs.clamp_out    = data[0];
        default: ;
      endcase
    endfunction

    function cmb_pkg::rgb_t blend_pixel(cmb_pkg::rgb_t a, cmb_pkg::rgb_t b,
                                        cmb_pkg::rgb_t fac);
      cmb_pkg::q_t av[3];
      cmb_pkg::q_t bv[3];
      cmb_pkg::q_t fv[3];
      cmb_pkg::q_t rv[3];
      cmb_pkg::q_t fm;
      cmb_pkg::q_t fc;
      cmb_pkg::q_t g;
      cmb_pkg::q_t v;
      av = '{a.r, a.g, a.b};
      bv = '{b.r, b.g, b.b};
      fv = '{fac.r, fac.g, fac.b};
      rv = '{default: '0};
      fm = clamp_unit(mean_of_three(fv[0], fv[1], fv[2]), regs.clamp_fac);
      case (regs.operand_kind)
        cmb_pkg::DT_FLOAT: begin
          g  = lerp_mix(mean_of_three(av[0], av[1], av[2]),
                        mean_of_three(bv[0], bv[1], bv[2]), fm);
          rv = '{g, g, g};
        end
        cmb_pkg::DT_VECTOR: begin
          for (int i = 0; i < 3; i++) begin
            fc    = regs.fac_per_chan ? clamp_unit(fv[i], regs.clamp_fac) : fm;
            rv[i] = lerp_mix(av[i], bv[i], fc);
          end
        end
        cmb_pkg::DT_COLOR: begin
          for (int i = 0; i < 3; i++) begin
            case (regs.blend_mode)
              cmb_pkg::BM_MIX: v = lerp_mix(av[i], bv[i], fm);
              cmb_pkg::BM_MUL: v = lerp_mul(av[i], bv[i], fm);
              cmb_pkg::BM_ADD: v = lerp_add(av[i], bv[i], fm);
              default:         v = '0;
            endcase
            rv[i] = clamp_unit(v, regs.clamp_out);
          end
        end
        default: ;
      endcase
      return '{rv[0], rv[1], rv[2]};
    endfunction

    function void note_request(cmb_pkg::rgb_t a, cmb_pkg::rgb_t b, cmb_pkg::rgb_t fac);
      pending_colors.push_back(blend_pixel(a, b, fac));
    endfunction

    function void check_channel(string name, cmb_pkg::q_t want, cmb_pkg::q_t got);
      if (want !== got) begin
        $display("%0t: %s channel mismatch, expected %0d, actual %0d",
                 $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cmb_pkg::rgb_t got);
      cmb_pkg::rgb_t want;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                 $time, got.r, got.g, got.b);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      check_channel("red", want.r, got.r);
      check_channel("green", want.g, got.g);
      check_channel("blue", want.b, got.b);
    endfunction
  endclass

endpackage

### dv/color_mix_blend_unit_tb.sv
// Testbench top for the color mix blend unit: directed corner pixels under
// every mode, then random pixels under random settings with random idling.
// Depends on cmb_pkg, the channel interfaces, cmb_blend_sb_pkg and the unit.

module color_mix_blend_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Unused data type code, and unused blend code in color mode, give zero.
  localparam logic [1:0] DT_UNUSED = 2'd3;
  localparam logic [1:0] BM_UNUSED = 2'd3;

  localparam cmb_pkg::q_t TOP  = 16'sh7fff;
  localparam cmb_pkg::q_t BOT  = -16'sd32768;
  localparam cmb_pkg::q_t HALF = 16'sd2048;

  // The pipeline is five stages deep; DRAIN_CYCLES leaves room for any
  // straggling result to show up after the queue empties.
  localparam int DRAIN_CYCLES = 8;
  // The longest legal quiet stretch is an idle gap plus the pipeline depth;
  // this limit sits far above that.
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int QUIET_PHASES = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  cmb_blend_sb_pkg::blend_scoreboard sb = new();

  cmb_in_if  in_bus();
  cmb_out_if out_bus();
  cmb_cfg_if cfg_bus();

  color_mix_blend_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every handshake is observed at the rising edge, where all inputs still
  // hold the values driven at the previous edge. Requests feed the
  // predictor, results are checked in order, and register writes update the
  // scoreboard's copy of the configuration. The same block runs the
  // watchdog: a quiet counter, cleared by any handshake and in reset,
  // declares the run hung when it reaches its limit.
  always @(posedge clk) begin
    cmb_pkg::rgb_t a_s;
    cmb_pkg::rgb_t b_s;
    cmb_pkg::rgb_t f_s;
    cmb_pkg::rgb_t got;
    logic moved;
    moved = 1'b0;
    if (in_bus.valid && in_bus.ready) begin
      a_s = '{in_bus.a_r, in_bus.a_g, in_bus.a_b};
      b_s = '{in_bus.b_r, in_bus.b_g, in_bus.b_b};
      f_s = '{in_bus.fac_r, in_bus.fac_g, in_bus.fac_b};
      sb.note_request(a_s, b_s, f_s);
      moved = 1'b1;
    end
    if (out_bus.valid && out_bus.ready) begin
      got = '{out_bus.out_r, out_bus.out_g, out_bus.out_b};
      sb.check_result(got);
      moved = 1'b1;
    end
    if (cfg_bus.valid && cfg_bus.ready) begin
      sb.write_reg(cfg_bus.index, cfg_bus.data);
      moved = 1'b1;
    end
    if (moved || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side drops ready in random bursts. The chance of starting
  // a burst is set per phase, and it is zero in the closing phases so the
  // run ends with the unit streaming at full rate.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_bus.ready <= 1'b0;
        hold_left = $urandom_range(1, 10) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic cmb_pkg::rgb_t make_rgb(cmb_pkg::q_t r, cmb_pkg::q_t g,
                                             cmb_pkg::q_t b);
    cmb_pkg::rgb_t c;
    c.r = r;
    c.g = g;
    c.b = b;
    return c;
  endfunction

  // Random channel values: the full 16 bit range, the region around the
  // unit interval, the saturation corners, and for factors 0..1, else -1..1.
  function automatic cmb_pkg::q_t rand_q(bit as_factor);
    case ($urandom_range(0, 3))
      0: return cmb_pkg::q_t'($urandom);
      1: return cmb_pkg::q_t'(int'($urandom_range(0, 8192)) - 2048);
      2: begin
        case ($urandom_range(0, 5))
          0: return BOT;
          1: return TOP;
          2: return '0;
          3: return cmb_pkg::Q_ONE;
          4: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return as_factor ? cmb_pkg::q_t'($urandom_range(0, 4096))
                                : cmb_pkg::q_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic cmb_pkg::rgb_t rand_rgb(bit as_factor);
    return make_rgb(rand_q(as_factor), rand_q(as_factor), rand_q(as_factor));
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  // Random settings lean toward the defined codes but still visit the
  // unused data type and blend code now and then.
  function automatic cmb_pkg::cfg_t random_setting();
    cmb_pkg::cfg_t s;
    s.operand_kind = ($urandom_range(0, 7) == 0) ? DT_UNUSED : 2'($urandom_range(0, 2));
    s.fac_per_chan = 1'($urandom_range(0, 1));
    s.blend_mode   = ($urandom_range(0, 7) == 0) ? BM_UNUSED : 2'($urandom_range(0, 2));
    s.clamp_fac    = 1'($urandom_range(0, 1));
    s.clamp_out    = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Settings for the directed part. Together they reach every blend, both
  // factor modes, both clamps, the unused codes, and the bits that must be
  // ignored: the factor mode outside vector mode and the result clamp
  // outside color mode.
  function automatic cmb_pkg::cfg_t corner_setting(int i);
    case (i)
      0: return '{cmb_pkg::DT_COLOR,  1'b0, cmb_pkg::BM_MIX, 1'b0, 1'b0};
      1: return '{cmb_pkg::DT_COLOR,  1'b0, cmb_pkg::BM_MUL, 1'b1, 1'b0};
      2: return '{cmb_pkg::DT_COLOR,  1'b0, cmb_pkg::BM_ADD, 1'b0, 1'b1};
      3: return '{cmb_pkg::DT_COLOR,  1'b1, BM_UNUSED,       1'b0, 1'b1};
      4: return '{cmb_pkg::DT_FLOAT,  1'b1, cmb_pkg::BM_MUL, 1'b0, 1'b1};
      5: return '{cmb_pkg::DT_FLOAT,  1'b0, cmb_pkg::BM_MIX, 1'b1, 1'b0};
      6: return '{cmb_pkg::DT_VECTOR, 1'b0, cmb_pkg::BM_ADD, 1'b0, 1'b1};
      7: return '{cmb_pkg::DT_VECTOR, 1'b1, cmb_pkg::BM_MIX, 1'b1, 1'b0};
      default: return '{DT_UNUSED, 1'b1, cmb_pkg::BM_MUL, 1'b1, 1'b1};
    endcase
  endfunction

  // Corner pixels: full scale swings that saturate, a factor at the most
  // negative value, factors above one, per channel factors that differ,
  // exact rounding ties, and a zero factor mean from channels not all zero.
  function automatic void corner_pixel(int k, output cmb_pkg::rgb_t a,
                                       output cmb_pkg::rgb_t b,
                                       output cmb_pkg::rgb_t f);
    case (k)
      0: begin
        a = make_rgb(TOP, TOP, TOP);
        b = make_rgb(BOT, BOT, BOT);
        f = make_rgb(cmb_pkg::Q_ONE, cmb_pkg::Q_ONE, cmb_pkg::Q_ONE);
      end
      1: begin
        a = make_rgb(BOT, BOT, BOT);
        b = make_rgb(TOP, TOP, TOP);
        f = make_rgb(BOT, BOT, BOT);
      end
      2: begin
        a = make_rgb(TOP, BOT, '0);
        b = make_rgb(BOT, TOP, cmb_pkg::Q_ONE);
        f = make_rgb(TOP, TOP, TOP);
      end
      3: begin
        a = make_rgb(cmb_pkg::Q_ONE, HALF, -16'sd1);
        b = make_rgb('0, -cmb_pkg::Q_ONE, 16'sd1);
        f = make_rgb('0, cmb_pkg::Q_ONE, HALF);
      end
      4: begin
        a = make_rgb('0, '0, '0);
        b = make_rgb(16'sd1, -16'sd1, 16'sd3);
        f = make_rgb(HALF, HALF, HALF);
      end
      default: begin
        a = make_rgb(-16'sd1, 16'sd1, TOP);
        b = make_rgb(TOP, BOT, -16'sd1);
        f = make_rgb(16'sd1, -16'sd1, '0);
      end
    endcase
  endfunction

  // Writes all five registers back to back, keeping valid high between
  // writes. Unused upper data bits carry random values, and about half the
  // time a write to an index past the register list follows, which the
  // unit must ignore.
  task automatic write_setting(cmb_pkg::cfg_t s);
    logic [cmb_pkg::CFG_IDX_W-1:0]  idx [6];
    logic [cmb_pkg::CFG_DATA_W-1:0] val [6];
    int count;
    count = 5;
    idx[0] = cmb_pkg::CFG_OPERAND_KIND;
    idx[1] = cmb_pkg::CFG_FAC_PER_CHAN;
    idx[2] = cmb_pkg::CFG_BLEND_MODE;
    idx[3] = cmb_pkg::CFG_CLAMP_FAC;
    idx[4] = cmb_pkg::CFG_CLAMP_OUT;
    for (int k = 0; k < 6; k++) val[k] = cmb_pkg::CFG_DATA_W'($urandom);
    val[0][1:0] = s.operand_kind;
    val[1][0]   = s.fac_per_chan;
    val[2][1:0] = s.blend_mode;
    val[3][0]   = s.clamp_fac;
    val[4][0]   = s.clamp_out;
    if ($urandom_range(0, 1) == 1) begin
      idx[5] = cmb_pkg::CFG_CLAMP_OUT + cmb_pkg::CFG_IDX_W'($urandom_range(1, 3));
      count  = 6;
    end
    for (int k = 0; k < count; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Presents one request and holds it until the unit takes it. Valid stays
  // high into the next request unless an idle burst is drawn, in which
  // case it drops until the next request.
  task automatic send_pixel(cmb_pkg::rgb_t a, cmb_pkg::rgb_t b, cmb_pkg::rgb_t f);
    in_bus.valid <= 1'b1;
    in_bus.a_r   <= a.r;
    in_bus.a_g   <= a.g;
    in_bus.a_b   <= a.b;
    in_bus.b_r   <= b.r;
    in_bus.b_g   <= b.g;
    in_bus.b_b   <= b.b;
    in_bus.fac_r <= f.r;
    in_bus.fac_g <= f.g;
    in_bus.fac_b <= f.b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // A quarter of the random requests use a uniform factor color, so the
  // factor mean is exact and vector mode's two factor paths agree.
  task automatic run_phase(int items);
    cmb_pkg::rgb_t a;
    cmb_pkg::rgb_t b;
    cmb_pkg::rgb_t f;
    for (int n = 0; n < items; n++) begin
      a = rand_rgb(1'b0);
      b = rand_rgb(1'b0);
      f = rand_rgb(1'b1);
      if ($urandom_range(0, 3) == 0) begin
        f.g = f.r;
        f.b = f.r;
      end
      send_pixel(a, b, f);
    end
    in_bus.valid <= 1'b0;
  endtask

  // Waits until every predicted color has come back, then lets the
  // pipeline run empty so that a configuration write cannot hit a request
  // still in flight.
  task automatic wait_idle();
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cmb_pkg::rgb_t a;
    cmb_pkg::rgb_t b;
    cmb_pkg::rgb_t f;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.a_r    <= '0;
    in_bus.a_g    <= '0;
    in_bus.a_b    <= '0;
    in_bus.b_r    <= '0;
    in_bus.b_g    <= '0;
    in_bus.b_b    <= '0;
    in_bus.fac_r  <= '0;
    in_bus.fac_g  <= '0;
    in_bus.fac_b  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: three corner pixels under each of nine settings, sent
    // without idling on the request side.
    for (int i = 0; i < 9; i++) begin
      write_setting(corner_setting(i));
      for (int k = 0; k < 3; k++) begin
        corner_pixel((i + 2 * k) % 6, a, b, f);
        send_pixel(a, b, f);
      end
      in_bus.valid <= 1'b0;
      wait_idle();
    end

    // Random part: each phase picks a new setting and new idle rates; the
    // closing phases run with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - QUIET_PHASES) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
      end
      write_setting(random_setting());
      run_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### color_mix_blend_unit.f
rtl/core/cmb_pkg.sv
rtl/core/cmb_in_if.sv
rtl/core/cmb_out_if.sv
rtl/core/cmb_cfg_if.sv
rtl/core/cmb_mean_stage.sv
rtl/core/cmb_blend_stage.sv
rtl/core/color_mix_blend_unit.sv
dv/cmb_blend_sb_pkg.sv
dv/color_mix_blend_unit_tb.sv
